@@ src/pest_pkg.sv @@
// ----------------------------------------------------------------------------
// pest_pkg
// Shared types and constants for the sighting table: request broadcast,
// write-back broadcast, the scan beat carried along the cell chain, codes.
// ----------------------------------------------------------------------------
package pest_pkg;

    localparam int IDENT_W  = 56;
    localparam int LEVEL_W  = 8;
    localparam int TIME_W   = 32;
    localparam int CLASS_W  = 3;
    localparam int SLOT_W   = 4;
    localparam int SLOT_ID_W = 8;
    localparam int CFG_W    = 32;

    localparam logic [LEVEL_W-1:0] LEVEL_MIN = 8'sh81;  // -127

    localparam logic REG_EXPIRE = 1'b0;
    localparam logic REG_FLAG   = 1'b1;

    localparam logic [CFG_W-1:0]   EXPIRE_RESET = 32'd30000;
    localparam logic [CLASS_W-1:0] FLAG_RESET   = 3'd4;

    localparam logic [1:0] RANK_PLAIN   = 2'd0;
    localparam logic [1:0] RANK_NAMED   = 2'd1;
    localparam logic [1:0] RANK_FLAGGED = 2'd2;

    typedef enum logic [1:0] {
        EV_NONE       = 2'd0,
        EV_DISCOVERED = 2'd1,
        EV_NAMED      = 2'd2,
        EV_FLAGGED    = 2'd3
    } event_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXPIRE,
        ST_SCAN
    } state_t;

    // sighting held steady for the whole scan
    typedef struct packed {
        logic [IDENT_W-1:0] ident;
        logic [TIME_W-1:0]  now;
        logic [CFG_W-1:0]   expire_ticks;
        logic [CLASS_W-1:0] flag_level;
        logic [1:0]         in_rank;
    } req_t;

    // write-back to one cell
    typedef struct packed {
        logic                 en;
        logic [SLOT_ID_W-1:0] idx;
        logic [IDENT_W-1:0]   ident;
        logic [LEVEL_W-1:0]   level;
        logic [TIME_W-1:0]    seen;
        logic                 named;
        logic [CLASS_W-1:0]   cls;
    } wr_t;

    // running scan result handed from cell to cell
    typedef struct packed {
        logic                 match_hit;
        logic [SLOT_ID_W-1:0] match_id;
        logic                 match_named;
        logic [CLASS_W-1:0]   match_cls;
        logic [LEVEL_W-1:0]   match_level;
        logic                 free_hit;
        logic [SLOT_ID_W-1:0] free_id;
        logic                 ev_hit;
        logic [SLOT_ID_W-1:0] ev_id;
        logic [1:0]           ev_rank;
        logic [TIME_W-1:0]    ev_age;
    } acc_t;

    function automatic logic [1:0] rank_of(input logic named, input logic [CLASS_W-1:0] cls,
                                           input logic [CLASS_W-1:0] flag_level);
        logic [1:0] r;
        if (cls >= flag_level)
            r = RANK_FLAGGED;
        else if (named)
            r = RANK_NAMED;
        else
            r = RANK_PLAIN;
        return r;
    endfunction

endpackage

@@ src/priority_evicting_sighting_table.sv @@
// ----------------------------------------------------------------------------
// priority_evicting_sighting_table
// Sighting table of SLOTS entries built as a chain of cells with a sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   A sighting beat is taken when start is high and busy is low. Its fields
//   (identity, has_name, rssi, now, match_class) are captured at that edge.
//   The block then runs an expiry step, in which every cell ages itself in
//   parallel, and then a scan while the scan beat ripples from cell to cell
//   down the chain. At the end of the scan the chosen slot is written back
//   and the result beat appears for one cycle with done high.
//   The scan beat crosses one cell per cycle. A new start is taken in the
//   cycle the result is shown, so a new sighting is only taken once the
//   previous one is through.
//   Configuration (cfg_we, cfg_index, cfg_data) is written in one cycle and
//   should only be written while busy is low.
//   Reset empties the table and loads expire_ticks 30000 and flag_level 4.
//   The receiver cannot stall: each result is valid for its done cycle only.
// ----------------------------------------------------------------------------
module priority_evicting_sighting_table #(
    parameter int SLOTS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [pest_pkg::IDENT_W-1:0] identity,
    input  logic                         has_name,
    input  logic signed [7:0]            rssi,
    input  logic [pest_pkg::TIME_W-1:0]  now,
    input  logic [pest_pkg::CLASS_W-1:0] match_class,
    output logic                         done,
    output logic [1:0]                   event_res,
    output logic [pest_pkg::SLOT_W-1:0]  slot,
    output logic                         stored,
    output logic signed [7:0]            rssi_avg,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [pest_pkg::CFG_W-1:0]   cfg_data
);
    import pest_pkg::*;

    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SLOTS);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CFG_W-1:0]   expire_reg;
    logic [CLASS_W-1:0] flag_reg;

    logic [IDENT_W-1:0] ident_reg;
    logic               named_in_reg;
    logic [LEVEL_W-1:0] rssi_reg;
    logic [TIME_W-1:0]  now_reg;
    logic [CLASS_W-1:0] cls_reg;

    logic               done_reg, done_next;
    event_t             ev_reg, ev_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic               stored_reg, stored_next;
    logic [LEVEL_W-1:0] avg_reg, avg_next;

    logic [LEVEL_W-1:0] rssi_clamped;
    logic               accept;
    req_t               req;
    wr_t                wr;
    logic               expire_en;
    acc_t               chain [0:SLOTS];
    acc_t               fin;

    logic signed [10:0] sum3;
    logic signed [10:0] sum_adj;
    logic [LEVEL_W-1:0] lvl_upd;
    logic [CLASS_W-1:0] cls_old, cls_new;
    logic               named_old, named_new, flag_old, flag_new;
    logic [SLOT_ID_W-1:0] pick_id;
    logic               keep;

    assign accept = start && !busy;

    // clamp signal strength to -127..0
    always_comb
    begin
        priority if (!rssi[7] && (rssi != 8'sd0))
            rssi_clamped = '0;
        else if (rssi == -8'sd128)
            rssi_clamped = LEVEL_MIN;
        else
            rssi_clamped = rssi;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expire_reg <= EXPIRE_RESET;
            flag_reg   <= FLAG_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_EXPIRE: expire_reg <= cfg_data;
                REG_FLAG:   flag_reg   <= cfg_data[CLASS_W-1:0];
                default:    expire_reg <= expire_reg;
            endcase
        end
    end

    // capture the sighting beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ident_reg    <= identity;
            named_in_reg <= has_name;
            rssi_reg     <= rssi_clamped;
            now_reg      <= now;
            cls_reg      <= match_class;
        end
    end

    assign req.ident        = ident_reg;
    assign req.now          = now_reg;
    assign req.expire_ticks = expire_reg;
    assign req.flag_level   = flag_reg;
    assign req.in_rank      = rank_of(named_in_reg, cls_reg, flag_reg);

    // the cell chain
    assign chain[0] = '0;
    for (genvar g = 0; g < SLOTS; g++)
    begin : g_cell
        pest_cell #(
            .CELL_ID(g)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .expire_en(expire_en),
            .req      (req),
            .wr       (wr),
            .acc_in   (chain[g]),
            .acc_out  (chain[g+1])
        );
    end
    assign fin = chain[SLOTS];

    // smoothing: (3*old + new) / 4, truncated toward zero
    assign sum3    = 11'(signed'(fin.match_level)) * 11'sd3 + 11'(signed'(rssi_reg));
    assign sum_adj = sum3[10] ? (sum3 + 11'sd3) : sum3;
    assign lvl_upd = LEVEL_W'(sum_adj >>> 2);

    // outcome of the finished scan
    always_comb
    begin
        cls_old   = fin.match_hit ? fin.match_cls : '0;
        named_old = fin.match_hit && fin.match_named;
        cls_new   = (cls_reg > cls_old) ? cls_reg : cls_old;
        named_new = named_in_reg || named_old;
        flag_old  = fin.match_hit && (fin.match_cls >= flag_reg);
        flag_new  = cls_new >= flag_reg;
        keep      = fin.match_hit || fin.free_hit || fin.ev_hit;
        priority if (fin.match_hit)
            pick_id = fin.match_id;
        else if (fin.free_hit)
            pick_id = fin.free_id;
        else
            pick_id = fin.ev_id;
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ev_reg     <= ev_next;
        slot_reg   <= slot_next;
        stored_reg <= stored_next;
        avg_reg    <= avg_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        ev_next     = ev_reg;
        slot_next   = slot_reg;
        stored_next = stored_reg;
        avg_next    = avg_reg;
        expire_en   = 1'b0;
        wr          = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_EXPIRE;
            end
            ST_EXPIRE:
            begin
                expire_en  = 1'b1;
                cnt_next   = '0;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next  = ST_IDLE;
                    done_next   = 1'b1;
                    stored_next = keep;
                    wr.en       = keep;
                    wr.idx      = pick_id;
                    wr.ident    = ident_reg;
                    wr.level    = fin.match_hit ? lvl_upd : rssi_reg;
                    wr.seen     = now_reg;
                    wr.named    = named_new;
                    wr.cls      = cls_new;
                    if (keep)
                    begin
                        slot_next = pick_id[SLOT_W-1:0];
                        avg_next  = wr.level;
                        priority if (!flag_old && flag_new)
                            ev_next = EV_FLAGGED;
                        else if (named_new && !named_old)
                            ev_next = EV_NAMED;
                        else if (fin.match_hit)
                            ev_next = EV_NONE;
                        else
                            ev_next = EV_DISCOVERED;
                    end
                    else
                    begin
                        slot_next = '0;
                        avg_next  = '0;
                        ev_next   = EV_NONE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign event_res = ev_reg;
    assign slot      = slot_reg;
    assign stored    = stored_reg;
    assign rssi_avg  = avg_reg;

endmodule

@@ src/pest_cell.sv @@
// ----------------------------------------------------------------------------
// pest_cell
// One table entry. Expires itself on request, folds its entry into the scan
// beat from its left neighbour and registers the beat for its right one.
// ----------------------------------------------------------------------------
module pest_cell #(
    parameter int CELL_ID = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            expire_en,
    input  pest_pkg::req_t  req,
    input  pest_pkg::wr_t   wr,
    input  pest_pkg::acc_t  acc_in,
    output pest_pkg::acc_t  acc_out
);
    import pest_pkg::*;

    localparam logic [SLOT_ID_W-1:0] MY_ID = SLOT_ID_W'(CELL_ID);

    logic               valid_reg, valid_next;
    logic               named_reg, named_next;
    logic [CLASS_W-1:0] class_reg, class_next;
    logic [IDENT_W-1:0] ident_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic [TIME_W-1:0]  seen_reg;
    acc_t               acc_reg, acc_next;

    logic [TIME_W-1:0]  age;
    logic [1:0]         my_rank;
    logic               wr_hit;

    assign age     = req.now - seen_reg;
    assign my_rank = rank_of(named_reg, class_reg, req.flag_level);
    assign wr_hit  = wr.en && (wr.idx == MY_ID);

    // entry control: expiry clears, write-back fills
    always_comb
    begin
        valid_next = valid_reg;
        named_next = named_reg;
        class_next = class_reg;
        if (expire_en && valid_reg && (age >= req.expire_ticks))
        begin
            valid_next = 1'b0;
            named_next = 1'b0;
            class_next = '0;
        end
        else if (wr_hit)
        begin
            valid_next = 1'b1;
            named_next = wr.named;
            class_next = wr.cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            named_reg <= 1'b0;
            class_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            named_reg <= named_next;
            class_reg <= class_next;
        end
    end

    // entry payload
    always_ff @(posedge clk)
    begin
        if (wr_hit)
        begin
            ident_reg <= wr.ident;
            level_reg <= wr.level;
            seen_reg  <= wr.seen;
        end
    end

    // fold this entry into the passing scan beat
    always_comb
    begin
        acc_next = acc_in;
        if (valid_reg && (ident_reg == req.ident) && !acc_in.match_hit)
        begin
            acc_next.match_hit   = 1'b1;
            acc_next.match_id    = MY_ID;
            acc_next.match_named = named_reg;
            acc_next.match_cls   = class_reg;
            acc_next.match_level = level_reg;
        end
        if (!valid_reg && !acc_in.free_hit)
        begin
            acc_next.free_hit = 1'b1;
            acc_next.free_id  = MY_ID;
        end
        if (valid_reg && (my_rank <= req.in_rank))
        begin
            if (!acc_in.ev_hit || (my_rank < acc_in.ev_rank) ||
                ((my_rank == acc_in.ev_rank) && (age > acc_in.ev_age)))
            begin
                acc_next.ev_hit  = 1'b1;
                acc_next.ev_id   = MY_ID;
                acc_next.ev_rank = my_rank;
                acc_next.ev_age  = age;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acc_reg <= '0;
        else
            acc_reg <= acc_next;
    end

    assign acc_out = acc_reg;

endmodule

@@ src/pest_checker.sv @@
// ----------------------------------------------------------------------------
// pest_checker
// Port-level checks on the sighting table, bound to the top level.
// ----------------------------------------------------------------------------
module pest_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input logic              stored,
    input logic [3:0]        slot,
    input logic signed [7:0] rssi_avg
);

    // a taken sighting makes the block busy
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after start");

    // result beat only once the scan is over
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result while busy");

    // finishing a sighting always shows a result beat
    a_fell_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    // dropped sighting reports slot and level zero
    a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !stored) |-> (slot == 4'd0 && rssi_avg == 8'sd0))
        else $error("dropped sighting with nonzero fields");

    // smoothed level never positive
    a_avg_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && stored) |-> (rssi_avg <= 8'sd0))
        else $error("level out of range");

endmodule

bind priority_evicting_sighting_table pest_checker u_pest_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .done    (done),
    .stored  (stored),
    .slot    (slot),
    .rssi_avg(rssi_avg)
);
